@@ sv/fbr_pkg.sv @@
// shared constants, types and codes for the mono framebuffer line rasterizer
// no dependencies; imported by every module of the block
package fbr_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int STORE_DEPTH    = 1024;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int IN_W           = 12;
    localparam int COORD_W        = 14;
    localparam int DIFF_W         = 16;
    localparam int DATA_W         = 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [DATA_W-1:0]         byte_t;

    typedef enum logic [2:0] {
        CMD_PIXEL = 3'd0,
        CMD_LINE  = 3'd1,
        CMD_RECT  = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_PREP,
        LS_RUN
    } step_state_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT,
        ST_LINE_GO,
        ST_LINE_WAIT,
        ST_DRAIN,
        ST_READ,
        ST_READ_WAIT
    } top_state_t;

    // one pixel beat toward the read-modify-write pipeline
    typedef struct packed {
        logic   valid;
        coord_t x;
        coord_t y;
        logic   on;
    } pix_beat_t;

endpackage

@@ sv/fbr_line_stepper.sv @@
// bresenham stepper: orients a line, then emits one pixel coordinate per cycle
// depends on fbr_pkg
module fbr_line_stepper
    import fbr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   go,
    input  coord_t ax,
    input  coord_t ay,
    input  coord_t bx,
    input  coord_t by,
    output logic   busy,
    output logic   pix_valid,
    output coord_t pix_x,
    output coord_t pix_y
);

    step_state_t state_reg, state_next;

    logic   steep_reg, steep_next;
    coord_t u_reg, u_next;
    coord_t v_reg, v_next;
    coord_t u_end_reg, u_end_next;
    coord_t v_end_reg, v_end_next;
    diff_t  dx_reg, dx_next;
    diff_t  dy_reg, dy_next;
    diff_t  err_reg, err_next;
    logic   step_neg_reg, step_neg_next;

    diff_t  go_dx, go_dy, go_adx, go_ady;
    logic   go_steep;
    logic   prep_swap;
    coord_t p_u0, p_v0, p_u1, p_v1;
    diff_t  p_dx, p_dyr;
    diff_t  run_err;

    always_comb
    begin
        go_dx    = diff_t'(bx) - diff_t'(ax);
        go_dy    = diff_t'(by) - diff_t'(ay);
        go_adx   = (go_dx < 0) ? -go_dx : go_dx;
        go_ady   = (go_dy < 0) ? -go_dy : go_dy;
        go_steep = go_ady > go_adx;

        // order the ends so the major axis runs upward
        prep_swap = u_reg > u_end_reg;
        p_u0      = prep_swap ? u_end_reg : u_reg;
        p_v0      = prep_swap ? v_end_reg : v_reg;
        p_u1      = prep_swap ? u_reg : u_end_reg;
        p_v1      = prep_swap ? v_reg : v_end_reg;
        p_dx      = diff_t'(p_u1) - diff_t'(p_u0);
        p_dyr     = diff_t'(p_v1) - diff_t'(p_v0);

        run_err   = err_reg - dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        steep_next    = steep_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        u_end_next    = u_end_reg;
        v_end_next    = v_end_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        err_next      = err_reg;
        step_neg_next = step_neg_reg;
        pix_valid     = 1'b0;
        unique case (state_reg)
            LS_IDLE:
            begin
                if (go)
                begin
                    steep_next = go_steep;
                    u_next     = go_steep ? ay : ax;
                    v_next     = go_steep ? ax : ay;
                    u_end_next = go_steep ? by : bx;
                    v_end_next = go_steep ? bx : by;
                    state_next = LS_PREP;
                end
            end
            LS_PREP:
            begin
                u_next        = p_u0;
                v_next        = p_v0;
                u_end_next    = p_u1;
                dx_next       = p_dx;
                dy_next       = (p_dyr < 0) ? -p_dyr : p_dyr;
                err_next      = p_dx >>> 1;
                step_neg_next = !(p_v0 < p_v1);
                state_next    = LS_RUN;
            end
            LS_RUN:
            begin
                pix_valid = 1'b1;
                u_next    = u_reg + coord_t'(1);
                if (run_err < 0)
                begin
                    v_next   = step_neg_reg ? v_reg - coord_t'(1) : v_reg + coord_t'(1);
                    err_next = run_err + dx_reg;
                end
                else
                begin
                    err_next = run_err;
                end
                if (u_reg == u_end_reg)
                begin
                    state_next = LS_IDLE;
                end
            end
            default:
            begin
                state_next = LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        steep_reg    <= steep_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        u_end_reg    <= u_end_next;
        v_end_reg    <= v_end_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        err_reg      <= err_next;
        step_neg_reg <= step_neg_next;
    end

    assign busy  = state_reg != LS_IDLE;
    assign pix_x = steep_reg ? v_reg : u_reg;
    assign pix_y = steep_reg ? u_reg : v_reg;

    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == LS_IDLE)
        else $error("stepper started while busy");

    a_run_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == LS_RUN |-> u_reg <= u_end_reg)
        else $error("stepper ran past line end");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == LS_RUN |-> err_reg >= 0 && err_reg <= dx_reg)
        else $error("error term out of range");

endmodule

@@ sv/fbr_pixel_rmw.sv @@
// frame store with a two-stage read-modify-write pixel pipeline,
// a clear write port and a byte read port; depends on fbr_pkg
module fbr_pixel_rmw
    import fbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pix_beat_t pix,
    input  logic      clr_en,
    input  addr_t     clr_addr,
    input  logic      rd_en,
    input  addr_t     rd_addr,
    output byte_t     rd_data,
    output logic      pipe_busy
);

    localparam int     FULL_W = 24;
    localparam coord_t X_LIM  = coord_t'(DISPLAY_WIDTH);
    localparam coord_t Y_LIM  = coord_t'(DISPLAY_HEIGHT);

    byte_t mem [STORE_DEPTH];

    logic              s1_valid_reg;
    addr_t             s1_addr_reg;
    byte_t             s1_mask_reg;
    logic              s1_on_reg;
    logic              fwd_valid_reg;
    addr_t             fwd_addr_reg;
    byte_t             fwd_data_reg;
    byte_t             rdata_reg;

    logic              x_ok, y_ok, hit;
    logic [FULL_W-1:0] addr_full;
    byte_t             mask;
    logic              mem_ren, mem_we;
    addr_t             mem_raddr, mem_waddr;
    byte_t             mem_wdata;
    byte_t             old_byte, new_byte;

    always_comb
    begin
        x_ok      = (pix.x >= 0) && (pix.x < X_LIM);
        y_ok      = (pix.y >= 0) && (pix.y < Y_LIM);
        addr_full = FULL_W'($unsigned(pix.y[COORD_W-1:3])) * FULL_W'(DISPLAY_WIDTH)
                  + FULL_W'($unsigned(pix.x));
        hit       = pix.valid && x_ok && y_ok && (addr_full < FULL_W'(STORE_DEPTH));
        mask      = byte_t'(1) << pix.y[2:0];

        mem_ren   = hit || rd_en;
        mem_raddr = hit ? addr_full[ADDR_W-1:0] : rd_addr;

        // the previous write landed after this beat's read was issued
        old_byte  = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rdata_reg;
        new_byte  = s1_on_reg ? (old_byte | s1_mask_reg) : (old_byte & ~s1_mask_reg);

        mem_we    = s1_valid_reg || clr_en;
        mem_waddr = clr_en ? clr_addr : s1_addr_reg;
        mem_wdata = clr_en ? '0 : new_byte;
    end

    always_ff @(posedge clk)
    begin
        if (mem_ren)
        begin
            rdata_reg <= mem[mem_raddr];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= hit;
            fwd_valid_reg <= s1_valid_reg && !clr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= addr_full[ADDR_W-1:0];
        s1_mask_reg  <= mask;
        s1_on_reg    <= pix.on;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= new_byte;
    end

    assign rd_data   = rdata_reg;
    assign pipe_busy = s1_valid_reg;

    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        clr_en |-> !s1_valid_reg && !pix.valid)
        else $error("clear overlaps pixel traffic");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(pix.valid))
        else $error("pixel write without a pixel beat");

    a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !pix.valid && !s1_valid_reg)
        else $error("byte read overlaps pixel traffic");

endmodule

@@ sv/mono_framebuffer_line_rasterizer_unit.sv @@
// top level of the mono framebuffer line rasterizer: command sequencer
// depends on fbr_pkg, fbr_line_stepper and fbr_pixel_rmw
//
// One command is taken when start is high and busy is low; exactly one result
// beat follows, flagged by done for a single cycle, with read_data holding the
// addressed byte for a read and zero otherwise. The receiver cannot stall, so
// done must be sampled when it is high. Every pixel is a read-modify-write of
// the 1024-byte frame store, pipelined at one pixel per cycle. A line plots
// one pixel per step along its major axis, and a rectangle is drawn as one
// such line per column. After reset the store is swept to zero, one byte per
// cycle, and busy stays high until the sweep is over.
module mono_framebuffer_line_rasterizer_unit
    import fbr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             command,
    input  logic signed [IN_W-1:0] x_start,
    input  logic signed [IN_W-1:0] y_start,
    input  logic signed [IN_W-1:0] x_end,
    input  logic signed [IN_W-1:0] y_end,
    input  logic                   colour,
    input  logic [7:0]             rect_width,
    input  logic [7:0]             rect_height,
    input  logic [ADDR_W-1:0]      byte_index,
    output logic                   done,
    output logic [DATA_W-1:0]      read_data
);

    top_state_t state_reg, state_next;

    coord_t     ax_reg, ay_reg, bx_reg, by_reg;
    logic [7:0] cols_reg;
    logic       rect_reg;
    logic       colour_reg;
    addr_t      idx_reg;
    addr_t      clr_cnt_reg;
    logic       clear_item_reg;
    logic       done_reg;
    byte_t      read_data_reg;

    logic       accept;
    logic       finish;
    byte_t      finish_data;
    logic       col_adv;
    logic       plot_en;
    logic       step_go;
    logic       clr_en;
    logic       rd_en;
    cmd_t       cmd_in;

    logic       step_busy;
    logic       step_valid;
    coord_t     step_x, step_y;
    pix_beat_t  pix;
    byte_t      rd_data;
    logic       pipe_busy;

    assign cmd_in = cmd_t'(command);
    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        finish      = 1'b0;
        finish_data = '0;
        col_adv     = 1'b0;
        plot_en     = 1'b0;
        step_go     = 1'b0;
        clr_en      = 1'b0;
        rd_en       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_en = 1'b1;
                if (clr_cnt_reg == addr_t'(STORE_DEPTH - 1))
                begin
                    finish     = clear_item_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_in)
                        CMD_PIXEL: state_next = ST_PLOT;
                        CMD_LINE:  state_next = ST_LINE_GO;
                        CMD_RECT:
                        begin
                            if (rect_width == '0)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_LINE_GO;
                            end
                        end
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_READ:  state_next = ST_READ;
                        default:   finish = 1'b1;
                    endcase
                end
            end
            ST_PLOT:
            begin
                plot_en    = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_LINE_GO:
            begin
                step_go    = 1'b1;
                state_next = ST_LINE_WAIT;
            end
            ST_LINE_WAIT:
            begin
                if (!step_busy)
                begin
                    if (rect_reg && cols_reg != 8'd1)
                    begin
                        col_adv    = 1'b1;
                        state_next = ST_LINE_GO;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                finish      = 1'b1;
                finish_data = rd_data;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            clear_item_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + addr_t'(1);
            end
            if (accept && cmd_in == CMD_CLEAR)
            begin
                clear_item_reg <= 1'b1;
            end
            else if (finish)
            begin
                clear_item_reg <= 1'b0;
            end
            done_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            read_data_reg <= finish_data;
        end
        if (accept)
        begin
            rect_reg   <= cmd_in == CMD_RECT;
            colour_reg <= colour;
            idx_reg    <= byte_index;
            cols_reg   <= rect_width;
            ax_reg     <= coord_t'(x_start);
            ay_reg     <= coord_t'(y_start);
            if (cmd_in == CMD_RECT)
            begin
                // each column runs from the top row to top + height - 1
                bx_reg <= coord_t'(x_start);
                by_reg <= coord_t'(y_start) + coord_t'(rect_height) - coord_t'(1);
            end
            else
            begin
                bx_reg <= coord_t'(x_end);
                by_reg <= coord_t'(y_end);
            end
        end
        else if (col_adv)
        begin
            ax_reg   <= ax_reg + coord_t'(1);
            bx_reg   <= bx_reg + coord_t'(1);
            cols_reg <= cols_reg - 8'd1;
        end
    end

    fbr_line_stepper u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (step_go),
        .ax        (ax_reg),
        .ay        (ay_reg),
        .bx        (bx_reg),
        .by        (by_reg),
        .busy      (step_busy),
        .pix_valid (step_valid),
        .pix_x     (step_x),
        .pix_y     (step_y)
    );

    always_comb
    begin
        pix.valid = plot_en || step_valid;
        pix.x     = plot_en ? ax_reg : step_x;
        pix.y     = plot_en ? ay_reg : step_y;
        pix.on    = colour_reg;
    end

    fbr_pixel_rmw u_rmw (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .clr_en    (clr_en),
        .clr_addr  (clr_cnt_reg),
        .rd_en     (rd_en),
        .rd_addr   (idx_reg),
        .rd_data   (rd_data),
        .pipe_busy (pipe_busy)
    );

    assign done      = done_reg;
    assign read_data = read_data_reg;

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while a command is still running");

    a_drain_after_line: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> !step_busy)
        else $error("drain entered with the stepper active");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pipe_busy && !step_busy)
        else $error("idle with pixel writes outstanding");

endmodule
